@@ rtl/geco_pkg.sv @@
// Package with the item types, request codes and multiplier link types of the contraction core.
package geco_pkg;

  localparam logic [1:0] REQ_WEIGHT = 2'd0;
  localparam logic [1:0] REQ_EDGE   = 2'd1;
  localparam logic [1:0] REQ_START  = 2'd2;

  localparam logic CFG_VERTEX_COUNT = 1'b0;
  localparam logic CFG_EDGE_COUNT   = 1'b1;

  localparam int CFG_DATA_W = 6;

  localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [15:0] weight;
    logic [4:0]  edge_slot;
    logic [3:0]  end_a;
    logic [3:0]  end_b;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  edge_id;
    logic        contracted;
    logic [63:0] step_cost;
    logic [63:0] total_cost;
    logic        overflow;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] prod;
  } mul_rsp_t;

endpackage

@@ rtl/geco_in_if.sv @@
// Interface of the request channel of the contraction core.
interface geco_in_if;
  import geco_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/geco_out_if.sv @@
// Interface of the result channel of the contraction core.
interface geco_out_if;
  import geco_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/geco_mul.sv @@
// Multi-cycle 64 by 64 bit multiplier built from one 32 by 32 bit partial product per cycle.
module geco_mul (
  input  logic               clk,
  input  logic               rst,
  input  geco_pkg::mul_req_t req,
  output geco_pkg::mul_rsp_t rsp
);
  import geco_pkg::*;

  logic [63:0]  a_q;
  logic [63:0]  b_q;
  logic [127:0] acc;
  logic [1:0]   cnt;
  logic         busy;
  logic         done;
  logic [31:0]  ha;
  logic [31:0]  hb;
  logic [63:0]  pp;
  logic [6:0]   shamt;
  logic [127:0] pp_sh;

  always_comb begin
    ha = cnt[1] ? a_q[63:32] : a_q[31:0];
    hb = cnt[0] ? b_q[63:32] : b_q[31:0];
    pp = {32'd0, ha} * {32'd0, hb};
    if (cnt == 2'd0) begin
      shamt = 7'd0;
    end else if (cnt == 2'd3) begin
      shamt = 7'd64;
    end else begin
      shamt = 7'd32;
    end
    pp_sh = {64'd0, pp} << shamt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      done <= busy && !req.start && (cnt == 2'd3);
      if (req.start) begin
        a_q  <= req.a;
        b_q  <= req.b;
        acc  <= '0;
        cnt  <= 2'd0;
        busy <= 1'b1;
      end else if (busy) begin
        acc <= acc + pp_sh;
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.prod = acc;
endmodule

@@ rtl/greedy_edge_contraction_order_core.sv @@
// Top level of the greedy edge contraction order core.
//
// Requests arrive on in_ch: a weight load writes a bond dimension into the symmetric
// matrix at (row, col) and at (col, row), an edge load stores two endpoints, and a start
// builds the contraction order and sends one result item per edge on out_ch.
// vertex_count and edge_count are written through cfg_we, cfg_index and cfg_data.
// A start runs edge_count rounds; each round scores every open edge from its matrix
// factors, and a contraction then updates the matrix entries of every vertex.
// The run time is set by the one shared multiplier, which forms each 64 bit product, and
// by the one read port and one write port of the matrix memory. in_ch.ready is high only
// between requests. After reset the matrix memory is cleared, one entry a cycle,
// through all MAX_VERTICES * MAX_VERTICES entries before the first request is taken.
// Results wait in one output register; while out_ch stalls the core holds its
// next result and stops, and it continues once the register is taken.
module greedy_edge_contraction_order_core #(
  parameter int MAX_VERTICES = 16,
  parameter int MAX_EDGES    = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [geco_pkg::CFG_DATA_W-1:0] cfg_data,
  geco_in_if.sink                         in_ch,
  geco_out_if.source                      out_ch
);
  import geco_pkg::*;

  localparam int VI    = $clog2(MAX_VERTICES);
  localparam int VC    = $clog2(MAX_VERTICES + 1);
  localparam int EI    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EC    = $clog2(MAX_EDGES + 1);
  localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int AW    = $clog2(DEPTH);
  localparam int MW    = (VC > 4) ? VC : 4;

  typedef enum logic [26:0] {
    S_CLEAR  = 27'h000_0001,
    S_IDLE   = 27'h000_0002,
    S_MIRROR = 27'h000_0004,
    S_SCAN   = 27'h000_0008,
    S_EREAD  = 27'h000_0010,
    S_MOD    = 27'h000_0020,
    S_ROOTA  = 27'h000_0040,
    S_ROOTB  = 27'h000_0080,
    S_WREAD  = 27'h000_0100,
    S_WGET   = 27'h000_0200,
    S_XADDR  = 27'h000_0400,
    S_XGET   = 27'h000_0800,
    S_XMUL   = 27'h000_1000,
    S_SCORE  = 27'h000_2000,
    S_CMP1   = 27'h000_4000,
    S_CMP2   = 27'h000_8000,
    S_FIN    = 27'h001_0000,
    S_STEP   = 27'h002_0000,
    S_MRD1   = 27'h004_0000,
    S_MRD2   = 27'h008_0000,
    S_MMUL   = 27'h010_0000,
    S_MWAIT  = 27'h020_0000,
    S_MW1    = 27'h040_0000,
    S_MW2    = 27'h080_0000,
    S_MW3    = 27'h100_0000,
    S_MW4    = 27'h200_0000,
    S_EMIT   = 27'h400_0000
  } state_t;

  state_t state;
  state_t state_next;

  logic [4:0]  vertex_count;
  logic [5:0]  edge_count;

  logic [63:0]   dim_mem [DEPTH];
  logic [63:0]   mem_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [63:0]   mem_wdata;

  logic [7:0] edge_mem [MAX_EDGES];
  logic [7:0] edge_q;
  logic       edge_we;

  logic [VI-1:0]        rep [MAX_VERTICES];
  logic [VI-1:0]        rep_sel;
  logic [VI-1:0]        rep_rd;
  logic [MAX_EDGES-1:0] edge_done;

  logic [AW-1:0] clr_addr;
  logic [VI-1:0] ld_row;
  logic [VI-1:0] ld_col;
  logic [15:0]   ld_w;

  logic [VC-1:0] n_r;
  logic [VC-1:0] n_start;
  logic [EC-1:0] ecnt_r;
  logic [EC-1:0] ecnt_start;
  logic [EC-1:0] produced;
  logic [EC-1:0] e;
  logic          have;
  logic [MW-1:0] ma;
  logic [MW-1:0] mb;
  logic [VI-1:0] cur_i;
  logic [VI-1:0] cur_k;
  logic [VI-1:0] best_i;
  logic [VI-1:0] best_k;
  logic [EI-1:0] best;
  logic [63:0]   w_cur;
  logic [63:0]   x_acc;
  logic [63:0]   best_w;
  logic [63:0]   best_e;
  logic [63:0]   opa;
  logic [63:0]   pval;
  logic [63:0]   step_r;
  logic [63:0]   cost_sum;
  logic          merged_r;
  logic          sat_flag;
  logic [127:0]  p1;
  logic [VC:0]   t;
  logic [VC-1:0] jm;
  logic [VI-1:0] jv;
  logic [VI-1:0] tj;
  logic [VI-1:0] trow;
  logic          tskip;
  logic [63:0]   fac;
  logic [64:0]   add_sum;

  mul_req_t    mul_req;
  mul_rsp_t    mul_rsp;
  logic        mul_ovf;
  logic [63:0] mul_sat;

  logic      in_acc;
  logic      row_ok;
  logic      slot_ok;
  logic      out_free;
  logic      is_last;
  logic      out_valid;
  out_item_t out_data;

  function automatic logic [AW-1:0] maddr(input logic [VI-1:0] r, input logic [VI-1:0] c);
    maddr = AW'(int'(r) * MAX_VERTICES + int'(c));
  endfunction

  geco_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  assign in_ch.ready  = (state == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;
  assign out_free     = !out_valid || out_ch.ready;

  assign row_ok  = (int'(in_ch.data.row) < MAX_VERTICES) &&
                   (int'(in_ch.data.col) < MAX_VERTICES);
  assign slot_ok = int'(in_ch.data.edge_slot) < MAX_EDGES;
  assign edge_we = in_acc && (in_ch.data.req_type == REQ_EDGE) && slot_ok;

  assign mul_ovf = |mul_rsp.prod[127:64];
  assign mul_sat = mul_ovf ? U64_MAX : mul_rsp.prod[63:0];
  assign fac     = (mem_q == 64'd0) ? 64'd1 : mem_q;
  assign add_sum = {1'b0, cost_sum} + {1'b0, mul_sat};
  assign is_last = (produced + EC'(1)) == ecnt_r;

  assign tj      = VI'(t >> 1);
  assign trow    = t[0] ? cur_k : cur_i;
  assign tskip   = t[0] ? (tj == cur_i) : (tj == cur_k);
  assign jv      = VI'(jm);
  assign rep_sel = (state == S_ROOTA) ? cur_i : cur_k;
  assign rep_rd  = rep[rep_sel];

  always_comb begin
    if (vertex_count == 5'd0) begin
      n_start = VC'(1);
    end else if (int'(vertex_count) > MAX_VERTICES) begin
      n_start = VC'(MAX_VERTICES);
    end else begin
      n_start = VC'(vertex_count);
    end
    if (int'(edge_count) > MAX_EDGES) begin
      ecnt_start = EC'(MAX_EDGES);
    end else begin
      ecnt_start = EC'(edge_count);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      S_IDLE: begin
        if (in_acc && (in_ch.data.req_type == REQ_WEIGHT) && row_ok) begin
          mem_we    = 1'b1;
          mem_waddr = maddr(VI'(in_ch.data.row), VI'(in_ch.data.col));
          mem_wdata = {48'd0, in_ch.data.weight};
        end
      end
      S_MIRROR: begin
        mem_we    = 1'b1;
        mem_waddr = maddr(ld_col, ld_row);
        mem_wdata = {48'd0, ld_w};
      end
      S_WREAD: mem_raddr = maddr(cur_i, cur_k);
      S_XADDR: mem_raddr = maddr(trow, tj);
      S_MRD1:  mem_raddr = maddr(best_i, jv);
      S_MRD2:  mem_raddr = maddr(best_k, jv);
      S_MW1: begin
        mem_we    = 1'b1;
        mem_waddr = maddr(best_i, jv);
        mem_wdata = pval;
      end
      S_MW2: begin
        mem_we    = 1'b1;
        mem_waddr = maddr(best_k, jv);
      end
      S_MW3: begin
        mem_we    = 1'b1;
        mem_waddr = maddr(jv, best_k);
      end
      S_MW4: begin
        mem_we    = 1'b1;
        mem_waddr = maddr(jv, best_i);
        mem_wdata = pval;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    mul_req = '0;
    case (state)
      S_XGET: begin
        mul_req.start = (fac != 64'd1);
        mul_req.a     = x_acc;
        mul_req.b     = fac;
      end
      S_SCORE: begin
        mul_req.start = have;
        mul_req.a     = w_cur;
        mul_req.b     = best_e;
      end
      S_CMP1: begin
        mul_req.start = mul_rsp.done;
        mul_req.a     = best_w;
        mul_req.b     = x_acc;
      end
      S_FIN: begin
        mul_req.start = (best_i != best_k);
        mul_req.a     = best_e;
        mul_req.b     = best_w;
      end
      S_MMUL: begin
        mul_req.start = 1'b1;
        mul_req.a     = opa;
        mul_req.b     = mem_q;
      end
      default: begin
        mul_req.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          if ((in_ch.data.req_type == REQ_WEIGHT) && row_ok) begin
            state_next = S_MIRROR;
          end else if ((in_ch.data.req_type == REQ_START) && (ecnt_start != '0)) begin
            state_next = S_SCAN;
          end
        end
      end
      S_MIRROR: state_next = S_IDLE;
      S_SCAN: begin
        if (e == ecnt_r) begin
          state_next = S_FIN;
        end else if (!edge_done[EI'(e)]) begin
          state_next = S_EREAD;
        end
      end
      S_EREAD: state_next = S_MOD;
      S_MOD: begin
        if ((ma < MW'(n_r)) && (mb < MW'(n_r))) state_next = S_ROOTA;
      end
      S_ROOTA: begin
        if (rep_rd == cur_i) state_next = S_ROOTB;
      end
      S_ROOTB: begin
        if (rep_rd == cur_k) state_next = S_WREAD;
      end
      S_WREAD: state_next = S_WGET;
      S_WGET:  state_next = S_XADDR;
      S_XADDR: begin
        if (t == {n_r, 1'b0}) begin
          state_next = S_SCORE;
        end else if (!tskip) begin
          state_next = S_XGET;
        end
      end
      S_XGET: state_next = (fac != 64'd1) ? S_XMUL : S_XADDR;
      S_XMUL: begin
        if (mul_rsp.done) state_next = S_XADDR;
      end
      S_SCORE: state_next = have ? S_CMP1 : S_SCAN;
      S_CMP1: begin
        if (mul_rsp.done) state_next = S_CMP2;
      end
      S_CMP2: begin
        if (mul_rsp.done) state_next = S_SCAN;
      end
      S_FIN: state_next = (best_i != best_k) ? S_STEP : S_EMIT;
      S_STEP: begin
        if (mul_rsp.done) state_next = S_MRD1;
      end
      S_MRD1: state_next = (jm == n_r) ? S_EMIT : S_MRD2;
      S_MRD2: state_next = S_MMUL;
      S_MMUL: state_next = S_MWAIT;
      S_MWAIT: begin
        if (mul_rsp.done) state_next = S_MW1;
      end
      S_MW1: state_next = S_MW2;
      S_MW2: state_next = S_MW3;
      S_MW3: state_next = S_MW4;
      S_MW4: state_next = S_MRD1;
      S_EMIT: begin
        if (out_free) state_next = is_last ? S_IDLE : S_SCAN;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dim_mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= dim_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[EI'(in_ch.data.edge_slot)] <= {in_ch.data.end_b, in_ch.data.end_a};
    end
    edge_q <= edge_mem[EI'(e)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      vertex_count <= 5'd16;
      edge_count   <= 6'd32;
      out_valid    <= 1'b0;
      edge_done    <= '0;
      sat_flag     <= 1'b0;
      cost_sum     <= '0;
      have         <= 1'b0;
      produced     <= '0;
      e            <= '0;
      for (int v = 0; v < MAX_VERTICES; v++) begin
        rep[v] <= VI'(v);
      end
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_VERTEX_COUNT: vertex_count <= cfg_data[4:0];
          CFG_EDGE_COUNT:   edge_count   <= cfg_data;
          default:          edge_count   <= edge_count;
        endcase
      end
      if (out_valid && out_ch.ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: clr_addr <= clr_addr + AW'(1);
        S_IDLE: begin
          if (in_acc) begin
            ld_row <= VI'(in_ch.data.row);
            ld_col <= VI'(in_ch.data.col);
            ld_w   <= in_ch.data.weight;
            if (in_ch.data.req_type == REQ_START) begin
              for (int v = 0; v < MAX_VERTICES; v++) begin
                rep[v] <= VI'(v);
              end
              edge_done <= '0;
              cost_sum  <= '0;
              sat_flag  <= 1'b0;
              produced  <= '0;
              e         <= '0;
              have      <= 1'b0;
              n_r       <= n_start;
              ecnt_r    <= ecnt_start;
            end
          end
        end
        S_SCAN: begin
          if ((e != ecnt_r) && edge_done[EI'(e)]) e <= e + EC'(1);
        end
        S_EREAD: begin
          ma <= MW'(edge_q[3:0]);
          mb <= MW'(edge_q[7:4]);
        end
        S_MOD: begin
          if (ma >= MW'(n_r)) ma <= ma - MW'(n_r);
          if (mb >= MW'(n_r)) mb <= mb - MW'(n_r);
          cur_i <= VI'(ma);
          cur_k <= VI'(mb);
        end
        S_ROOTA: begin
          if (rep_rd != cur_i) cur_i <= rep_rd;
        end
        S_ROOTB: begin
          if (rep_rd != cur_k) cur_k <= rep_rd;
        end
        S_WGET: begin
          w_cur <= mem_q;
          x_acc <= 64'd1;
          t     <= '0;
        end
        S_XADDR: begin
          if ((t != {n_r, 1'b0}) && tskip) t <= t + (VC+1)'(1);
        end
        S_XGET: begin
          if (fac == 64'd1) t <= t + (VC+1)'(1);
        end
        S_XMUL: begin
          if (mul_rsp.done) begin
            x_acc    <= mul_sat;
            sat_flag <= sat_flag | mul_ovf;
            t        <= t + (VC+1)'(1);
          end
        end
        S_SCORE: begin
          if (!have) begin
            have   <= 1'b1;
            best   <= EI'(e);
            best_w <= w_cur;
            best_e <= x_acc;
            best_i <= cur_i;
            best_k <= cur_k;
            e      <= e + EC'(1);
          end
        end
        S_CMP1: begin
          if (mul_rsp.done) p1 <= mul_rsp.prod;
        end
        S_CMP2: begin
          if (mul_rsp.done) begin
            if (p1 > mul_rsp.prod) begin
              best   <= EI'(e);
              best_w <= w_cur;
              best_e <= x_acc;
              best_i <= cur_i;
              best_k <= cur_k;
            end
            e <= e + EC'(1);
          end
        end
        S_FIN: begin
          if (best_i == best_k) begin
            step_r   <= '0;
            merged_r <= 1'b0;
          end
        end
        S_STEP: begin
          if (mul_rsp.done) begin
            step_r   <= mul_sat;
            merged_r <= 1'b1;
            cost_sum <= add_sum[64] ? U64_MAX : add_sum[63:0];
            sat_flag <= sat_flag | mul_ovf | add_sum[64];
            jm       <= '0;
          end
        end
        S_MRD1: begin
          if (jm == n_r) rep[best_k] <= best_i;
        end
        S_MRD2: opa <= mem_q;
        S_MWAIT: begin
          if (mul_rsp.done) begin
            pval     <= mul_sat;
            sat_flag <= sat_flag | mul_ovf;
          end
        end
        S_MW4: jm <= jm + VC'(1);
        S_EMIT: begin
          if (out_free) begin
            out_valid           <= 1'b1;
            out_data.edge_id    <= 5'(best);
            out_data.contracted <= merged_r;
            out_data.step_cost  <= step_r;
            out_data.total_cost <= cost_sum;
            out_data.overflow   <= sat_flag;
            out_data.last       <= is_last;
            edge_done[best]     <= 1'b1;
            produced            <= produced + EC'(1);
            e                   <= '0;
            have                <= 1'b0;
          end
        end
        default: begin
          have <= have;
        end
      endcase
    end
  end

  a_mul_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mul_rsp.done |-> (state == S_XMUL || state == S_CMP1 || state == S_CMP2 ||
                      state == S_STEP || state == S_MWAIT))
    else $error("Multiplier finished outside a wait state.");

  a_emit_edge_open: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free) |-> !edge_done[best])
    else $error("An edge was reported twice in one order.");

  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (produced < ecnt_r))
    else $error("More results than edges in use.");

  a_idle_mul_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mul_req.start)
    else $error("Multiplier started while the core is idle.");
endmodule
